@@ rtl/assert_macros.svh @@
// assertion macros shared by the sorted list engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
// types and constants of the sorted list engine
`default_nettype none

package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ECNT_W   = 5;

    typedef enum logic [2:0] {
        ACT_INSERT       = 3'd0,
        ACT_REMOVE_VALUE = 3'd1,
        ACT_REMOVE_MIN   = 3'd2,
        ACT_REMOVE_MAX   = 3'd3,
        ACT_CLEAR        = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT_ALL,
        OP_SHIFT_GE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

    typedef struct packed {
        t_action                   action;
        logic signed [DATA_W-1:0]  data_value;
    } t_in;

    typedef struct packed {
        logic                      ok;
        logic signed [DATA_W-1:0]  head_value;
        logic signed [DATA_W-1:0]  tail_value;
        logic [ECNT_W-1:0]         entry_count;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/sle_cell.sv @@
// one storage cell of the sorted chain
`default_nettype none

module sle_cell (
    input  wire                                   i_clk,
    input  var sle_pkg::t_cell_ctrl               i_ctrl,
    input  wire                                   i_occ,
    input  wire                                   i_left_lt,
    input  wire signed [sle_pkg::DATA_W-1:0]      i_left_entry,
    input  wire signed [sle_pkg::DATA_W-1:0]      i_right_entry,
    output logic signed [sle_pkg::DATA_W-1:0]     o_entry,
    output logic                                  o_lt,
    output logic                                  o_eq
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;

    assign o_lt    = i_occ && (r_entry < i_ctrl.value);
    assign o_eq    = i_occ && (r_entry == i_ctrl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (!o_lt) begin
                    n_entry = i_left_lt ? i_ctrl.value : i_left_entry;
                end
            end
            OP_SHIFT_ALL: begin
                n_entry = i_right_entry;
            end
            OP_SHIFT_GE: begin
                if (!o_lt) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ rtl/sorted_list_engine.sv @@
// a transfer updates the cell chain and sets the pending flag; the result moves to
// the output register once that register is empty or being taken; the pending flag
// holds o_ready low only until then, so a waiting result in the output register does not
// block the next transfer, but the input then stalls until the output register is taken
// reset: synchronous active low, empties the list and the handshake state; cell
// contents are not cleared
`default_nettype none

`include "assert_macros.svh"

module sorted_list_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  var sle_pkg::t_in    i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output sle_pkg::t_out       o_data
);
    import sle_pkg::*;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_pend;
    logic                       r_ok;
    logic                       n_ok;
    logic                       r_out_valid;
    t_out                       r_out;
    t_cell_op                   op;
    t_cell_ctrl                 ctrl;
    logic                       in_fire;
    logic                       full;
    logic                       any_eq;
    logic signed [DATA_W-1:0]   entry  [CAPACITY];
    logic                       lt     [CAPACITY];
    logic [CAPACITY-1:0]        eq;
    logic [CAPACITY-1:0]        last;
    logic signed [DATA_W-1:0]   tail;

    assign o_ready = !r_pend;
    assign in_fire = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign any_eq  = |eq;

    assign ctrl.op    = in_fire ? op : OP_HOLD;
    assign ctrl.value = i_data.data_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic occ;
        assign occ     = (CNT_W'(g) < r_count);
        assign last[g] = (r_count == CNT_W'(g + 1));
        sle_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occ         (occ),
            .i_left_lt     ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
            .i_left_entry  (entry[(g == 0) ? 0 : g - 1]),
            .i_right_entry (entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry       (entry[g]),
            .o_lt          (lt[g]),
            .o_eq          (eq[g])
        );
    end

    always_comb begin
        tail = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tail = tail | (entry[k] & {DATA_W{last[k]}});
        end
    end

    always_comb begin
        op      = OP_HOLD;
        n_count = r_count;
        n_ok    = 1'b0;
        case (i_data.action)
            ACT_INSERT: begin
                if (!full) begin
                    op      = OP_INSERT;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            ACT_REMOVE_VALUE: begin
                if (any_eq) begin
                    op      = OP_SHIFT_GE;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            ACT_REMOVE_MIN: begin
                if (r_count != '0) begin
                    op      = OP_SHIFT_ALL;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            ACT_REMOVE_MAX: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
                r_ok    <= n_ok;
            end
            if (r_pend && (!r_out_valid || i_ready)) begin
                r_out_valid       <= 1'b1;
                r_pend            <= 1'b0;
                r_out.ok          <= r_ok;
                r_out.head_value  <= (r_count != '0) ? entry[0] : '0;
                r_out.tail_value  <= tail;
                r_out.entry_count <= ECNT_W'(r_count);
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `SLE_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `SLE_ASSERT_NEXT(a_clear_empties, in_fire && (i_data.action == ACT_CLEAR),
        r_count == '0, "clear left entries behind")
    `SLE_ASSERT_NEXT(a_fire_pends, in_fire, r_pend, "transfer did not start a result")
    `SLE_ASSERT_NEXT(a_pend_drains, r_pend && (!r_out_valid || i_ready),
        r_out_valid && !r_pend, "pending result not moved to output")
    `SLE_ASSERT_NOW(a_full_no_grow, in_fire && full && (i_data.action == ACT_INSERT),
        !n_ok && (n_count == r_count), "insert into full list accepted")

endmodule

`default_nettype wire
